// ===== hw/rtl/sfr_pkg.sv =====
// shared types and constants for the subfont record parser
// no dependencies; compiled first
package sfr_pkg;

	// line status codes as seen on the result channel
	typedef enum logic [2:0] {
		ST_PROGRESS  = 3'd0,
		ST_ACCEPTED  = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_RANGE     = 3'd3,
		ST_OVERFLOW  = 3'd4,
		ST_TAKEN     = 3'd5
	} status_t;

	// token parser phases, the second number of a range is a separate flag
	typedef enum logic [2:0] {
		PH_BETWEEN = 3'd0,
		PH_SIGN    = 3'd1,
		PH_ZERO    = 3'd2,
		PH_X       = 3'd3,
		PH_NUM     = 3'd4,
		PH_UNDER   = 3'd5,
		PH_SKIP    = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		BASE_DEC = 2'd0,
		BASE_OCT = 2'd1,
		BASE_HEX = 2'd2
	} base_t;

	// work handed from the front end to the table engine
	typedef enum logic [2:0] {
		OP_NONE   = 3'd0,
		OP_WRITE  = 3'd1,
		OP_SETPOS = 3'd2,
		OP_FAIL   = 3'd3,
		OP_LOOKUP = 3'd4
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic        new_line;
		logic        line_done;
		status_t     err;
		logic [15:0] lo;
		logic [15:0] hi;
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_FILL = 2'd1,
		BK_LOOK = 2'd2
	} bk_state_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	localparam logic [16:0] ACC_SAT = 17'h1FFFF;

endpackage

// ===== hw/rtl/sfr_ifs.sv =====
// valid/ready channel interfaces for the request and result sides
// standalone; used by the top level and its submodules
interface sfr_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] ch;
	logic [7:0] position;

	modport source(output valid, output cmd, output ch, output position, input ready);
	modport sink(input valid, input cmd, input ch, input position, output ready);
endinterface

interface sfr_rsp_if;
	logic        valid;
	logic        ready;
	logic        line_done;
	logic [2:0]  status;
	logic        code_valid;
	logic [15:0] code;

	modport source(output valid, output line_done, output status, output code_valid,
		output code, input ready);
	modport sink(input valid, input line_done, input status, input code_valid,
		input code, output ready);
endinterface

// ===== hw/rtl/sfr_front.sv =====
// front end: tokenizer and number reader, one request transfer per cycle while the op queue is not full
// depends on sfr_pkg and sfr_req_if
module sfr_front
	import sfr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_req_if.sink   req,
	input  logic      q_full,
	output logic      push,
	output op_t       op
);

	localparam logic [16:0] POS_MAX = 17'(TABLE_ENTRIES - 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;

	localparam logic [4:0] NO_DIGIT = 5'd16;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'd32, [8'd9:8'd13]};
	endfunction

	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [4:0] d;
		d = NO_DIGIT;
		if (c inside {[8'h30:8'h39]}) begin
			d = 5'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			d = 5'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			d = 5'(c - 8'h37);
		end
		return d;
	endfunction

	function automatic logic [4:0] radix_of(input base_t b);
		logic [4:0] r;
		case (b)
			BASE_HEX: r = 5'd16;
			BASE_OCT: r = 5'd8;
			default:  r = 5'd10;
		endcase
		return r;
	endfunction

	// first digit of a number: a negative nonzero value saturates at once
	function automatic logic [16:0] first_digit(input logic [4:0] d, input logic neg);
		return (neg && d != 5'd0) ? ACC_SAT : {12'b0, d};
	endfunction

	function automatic logic [16:0] add_digit(input logic [16:0] acc, input base_t b,
		input logic [4:0] d, input logic neg);
		logic [21:0] v;
		logic [16:0] r;
		case (b)
			BASE_HEX: v = {1'b0, acc, 4'b0};
			BASE_OCT: v = {2'b0, acc, 3'b0};
			default:  v = {2'b0, acc, 3'b0} + {4'b0, acc, 1'b0};
		endcase
		v = v + {17'b0, d};
		r = (v > {5'b0, ACC_SAT}) ? ACC_SAT : v[16:0];
		if (neg && r != 17'd0) begin
			r = ACC_SAT;
		end
		return r;
	endfunction

	phase_t      phase_q, phase_d;
	logic        second_q, second_d;
	logic [16:0] acc_q, acc_d;
	base_t       base_q, base_d;
	logic [15:0] first_q, first_d;
	logic        neg_q, neg_d;
	logic        open_q, open_d;

	// values as seen by this character, after the new-line reset
	phase_t      ph;
	logic        sec;
	logic [16:0] acc;
	base_t       base;
	logic [7:0]  c;
	logic [4:0]  d;
	logic        sep;
	logic        fail_en;
	status_t     fail_st;

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		ph      = open_q ? phase_q : PH_BETWEEN;
		sec     = open_q && second_q;
		acc     = open_q ? acc_q : 17'd0;
		base    = open_q ? base_q : BASE_DEC;
		c       = req.ch;
		d       = digit_of(c);
		sep     = (c == CH_NUL) || is_space(c);
		fail_en = 1'b0;
		fail_st = ST_PROGRESS;

		op           = '0;
		op.kind      = OP_NONE;
		op.err       = ST_PROGRESS;

		phase_d  = phase_q;
		second_d = second_q;
		acc_d    = acc_q;
		base_d   = base_q;
		first_d  = first_q;
		neg_d    = neg_q;
		open_d   = open_q;

		if (req.cmd) begin
			op.kind = OP_LOOKUP;
			op.lo   = {8'b0, req.position};
		end else begin
			op.new_line = !open_q;
			phase_d     = ph;
			second_d    = sec;
			acc_d       = acc;
			base_d      = base;
			first_d     = open_q ? first_q : 16'd0;
			neg_d       = open_q && neg_q;

			case (ph)
				PH_BETWEEN, PH_UNDER: begin
					if (is_space(c) || (c == CH_NUL && ph == PH_BETWEEN)) begin
						// separator, nothing to do
					end else if (c == CH_PLUS || c == CH_MINUS) begin
						neg_d    = (c == CH_MINUS);
						acc_d    = 17'd0;
						phase_d  = PH_SIGN;
						second_d = (ph == PH_UNDER);
					end else if (d < 5'd10) begin
						neg_d    = 1'b0;
						second_d = (ph == PH_UNDER);
						if (c == CH_ZERO) begin
							acc_d   = 17'd0;
							base_d  = BASE_OCT;
							phase_d = PH_ZERO;
						end else begin
							acc_d   = first_digit(d, 1'b0);
							base_d  = BASE_DEC;
							phase_d = PH_NUM;
						end
					end else begin
						fail_en = 1'b1;
						fail_st = ST_MALFORMED;
					end
				end
				PH_SIGN: begin
					if (d < 5'd10) begin
						if (c == CH_ZERO) begin
							acc_d   = 17'd0;
							base_d  = BASE_OCT;
							phase_d = PH_ZERO;
						end else begin
							acc_d   = first_digit(d, neg_q);
							base_d  = BASE_DEC;
							phase_d = PH_NUM;
						end
					end else begin
						fail_en = 1'b1;
						fail_st = ST_MALFORMED;
					end
				end
				PH_X: begin
					if (d < NO_DIGIT) begin
						acc_d   = first_digit(d, neg_q);
						phase_d = PH_NUM;
					end else begin
						fail_en = 1'b1;
						fail_st = ST_MALFORMED;
					end
				end
				PH_ZERO, PH_NUM: begin
					if (ph == PH_ZERO && (c == CH_X_LO || c == CH_X_UP)) begin
						base_d  = BASE_HEX;
						phase_d = PH_X;
					end else if (d < radix_of(base)) begin
						acc_d   = add_digit(acc, base, d, neg_q);
						phase_d = PH_NUM;
					end else if (sec) begin
						// end of the upper bound of a range
						if (acc[16]) begin
							fail_en = 1'b1;
							fail_st = ST_RANGE;
						end else if (!sep) begin
							fail_en = 1'b1;
							fail_st = ST_MALFORMED;
						end else if (acc[15:0] < first_q) begin
							fail_en = 1'b1;
							fail_st = ST_RANGE;
						end else begin
							op.kind  = OP_WRITE;
							op.lo    = first_q;
							op.hi    = acc[15:0];
							phase_d  = PH_BETWEEN;
							second_d = 1'b0;
						end
					end else if (sep) begin
						if (acc[16]) begin
							fail_en = 1'b1;
							fail_st = ST_RANGE;
						end else begin
							op.kind = OP_WRITE;
							op.lo   = acc[15:0];
							op.hi   = acc[15:0];
							phase_d = PH_BETWEEN;
						end
					end else if (c == CH_COLON) begin
						if (acc > POS_MAX) begin
							fail_en = 1'b1;
							fail_st = ST_RANGE;
						end else begin
							op.kind = OP_SETPOS;
							op.lo   = acc[15:0];
							phase_d = PH_BETWEEN;
						end
					end else if (c == CH_UNDER) begin
						if (acc[16]) begin
							fail_en = 1'b1;
							fail_st = ST_RANGE;
						end else begin
							first_d  = acc[15:0];
							phase_d  = PH_UNDER;
							second_d = 1'b0;
						end
					end else begin
						fail_en = 1'b1;
						fail_st = ST_MALFORMED;
					end
				end
				default: begin
					// skip to end of line
				end
			endcase

			if (fail_en) begin
				op.kind = OP_FAIL;
				op.err  = fail_st;
				phase_d = PH_SKIP;
			end

			if (c == CH_NUL) begin
				op.line_done = 1'b1;
				phase_d      = PH_BETWEEN;
				second_d     = 1'b0;
				open_d       = 1'b0;
			end else begin
				open_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_BETWEEN;
			second_q <= 1'b0;
			acc_q    <= 17'd0;
			base_q   <= BASE_DEC;
			first_q  <= 16'd0;
			neg_q    <= 1'b0;
			open_q   <= 1'b0;
		end else if (push) begin
			phase_q  <= phase_d;
			second_q <= second_d;
			acc_q    <= acc_d;
			base_q   <= base_d;
			first_q  <= first_d;
			neg_q    <= neg_d;
			open_q   <= open_d;
		end
	end

endmodule

// ===== hw/rtl/sfr_queue.sv =====
// small first-in first-out queue of table operations
// depends on sfr_pkg
module sfr_queue
	import sfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic q_valid,
	output op_t  pop_op
);

	op_t                 slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full    = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign pop_op  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/sfr_back.sv =====
// table engine: code memory, valid marks, write position, line status, result register
// depends on sfr_pkg and sfr_rsp_if
module sfr_back
	import sfr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  op_t       op,
	output logic      pop,
	sfr_rsp_if.source rsp
);

	localparam int PW = $clog2(TABLE_ENTRIES);

	bk_state_t            state_q, state_d;
	status_t              status_q, status_d;
	logic [PW:0]          wp_q, wp_d;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [15:0]          code_mem [TABLE_ENTRIES];
	logic [15:0]          cur_code_q;
	logic [15:0]          hi_q;
	logic                 done_pend_q;
	logic                 rd_valid_q;
	logic [15:0]          rd_code_q;

	logic                 out_valid_q;
	logic                 out_done_q;
	status_t              out_status_q;
	logic                 out_cvalid_q;
	logic [15:0]          out_code_q;

	logic                 slot_free;
	logic                 take;
	status_t              eff_status;
	logic [PW:0]          eff_wp;
	logic [17:0]          reach;
	logic                 live;
	logic                 overflow;
	logic                 start_fill;
	logic                 hit_taken;
	logic                 fill_end;
	logic                 mem_we;
	logic                 clear_marks;
	logic [PW-1:0]        rd_idx;
	logic                 rd_in_range;
	logic                 emit;
	logic                 emit_done;
	logic                 emit_cvalid;
	logic [15:0]          emit_code;

	assign rsp.valid      = out_valid_q;
	assign rsp.line_done  = out_done_q;
	assign rsp.status     = out_status_q;
	assign rsp.code_valid = out_cvalid_q;
	assign rsp.code       = out_code_q;

	always_comb begin : next_state
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take && op.kind == OP_LOOKUP) begin
					state_d = BK_LOOK;
				end else if (start_fill) begin
					state_d = BK_FILL;
				end
			end
			BK_FILL: begin
				if (fill_end) begin
					state_d = BK_IDLE;
				end
			end
			BK_LOOK: state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin : outputs
		slot_free   = !out_valid_q || rsp.ready;
		take        = (state_q == BK_IDLE) && q_valid && slot_free;
		pop         = take;
		eff_status  = op.new_line ? ST_PROGRESS : status_q;
		eff_wp      = op.new_line ? '0 : wp_q;
		reach       = 18'(eff_wp) + ({2'b0, op.hi} - {2'b0, op.lo});
		overflow    = reach > 18'(TABLE_ENTRIES - 1);
		live        = (eff_status == ST_PROGRESS);
		start_fill  = take && op.kind == OP_WRITE && live && !overflow;
		hit_taken   = valid_q[wp_q[PW-1:0]];
		fill_end    = (state_q == BK_FILL) && (hit_taken || cur_code_q == hi_q);
		mem_we      = (state_q == BK_FILL) && !hit_taken;
		rd_idx      = op.lo[PW-1:0];
		rd_in_range = op.lo < 16'(TABLE_ENTRIES);

		clear_marks = 1'b0;
		status_d    = status_q;
		wp_d        = wp_q;
		emit        = 1'b0;
		emit_done   = 1'b0;
		emit_cvalid = 1'b0;
		emit_code   = 16'd0;

		case (state_q)
			BK_IDLE: begin
				if (take) begin
					clear_marks = op.new_line;
					status_d    = eff_status;
					wp_d        = eff_wp;
					case (op.kind)
						OP_SETPOS: begin
							if (live) begin
								wp_d = op.lo[PW:0];
							end
						end
						OP_FAIL: begin
							if (live) begin
								status_d = op.err;
							end
						end
						OP_WRITE: begin
							if (live && overflow) begin
								status_d = ST_OVERFLOW;
							end
						end
						default: begin
						end
					endcase
					emit      = (op.kind != OP_LOOKUP) && !start_fill;
					emit_done = op.line_done;
				end
			end
			BK_FILL: begin
				if (hit_taken) begin
					status_d = ST_TAKEN;
				end else begin
					wp_d = wp_q + 1'b1;
				end
				emit      = fill_end;
				emit_done = done_pend_q;
			end
			BK_LOOK: begin
				emit        = 1'b1;
				emit_cvalid = rd_valid_q;
				emit_code   = rd_valid_q ? rd_code_q : 16'd0;
			end
			default: begin
			end
		endcase

		// line end with no error seen
		if (emit && emit_done && status_d == ST_PROGRESS) begin
			status_d = ST_ACCEPTED;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			code_mem[wp_q[PW-1:0]] <= cur_code_q;
		end
		if (take && op.kind == OP_LOOKUP) begin
			rd_code_q  <= code_mem[rd_idx];
			rd_valid_q <= rd_in_range && valid_q[rd_idx];
		end
		if (start_fill) begin
			cur_code_q  <= op.lo;
			hi_q        <= op.hi;
			done_pend_q <= op.line_done;
		end else if (mem_we) begin
			cur_code_q <= cur_code_q + 1'b1;
		end
		if (emit) begin
			out_done_q   <= emit_done;
			out_status_q <= status_d;
			out_cvalid_q <= emit_cvalid;
			out_code_q   <= emit_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			status_q    <= ST_PROGRESS;
			wp_q        <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			wp_q     <= wp_d;
			if (clear_marks) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[wp_q[PW-1:0]] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hw/rtl/subfont_record_parser.sv =====
// top level of the subfont record line parser with its position-to-code table
// depends on sfr_pkg, sfr_ifs, sfr_front, sfr_queue and sfr_back
//
//   channel | dir | payload                              | transfer when
//   --------+-----+--------------------------------------+--------------------------
//   req     | in  | cmd, ch[7:0], position[7:0]          | req.valid && req.ready
//   rsp     | out | line_done, status[2:0], code_valid,  | rsp.valid && rsp.ready
//           |     | code[15:0]                           |
//
// flow: the front end takes one request per cycle while the four-entry op queue
//   has room; the table engine answers a plain character from its idle state, a
//   lookup via its look state (registered code memory read) and a token that
//   writes codes via its fill state, one write per cycle; long ranges set the pace
// reset: arst_n clears parser, status, write position and all valid marks; the
//   code memory itself holds garbage until written and is never returned unmarked
// stalls: a held result blocks the engine, the queue fills, then req.ready drops
module subfont_record_parser
	import sfr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	sfr_req_if.sink   req,
	sfr_rsp_if.source rsp
);

	// front end to queue
	logic push;
	op_t  push_op;
	logic q_full;

	// queue to table engine
	logic pop;
	logic q_valid;
	op_t  pop_op;

	// tokenizer: classifies each character and emits one op per request
	sfr_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.op     (push_op)
	);

	// decouples parsing from the table writes of the fill state
	sfr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.pop_op  (pop_op)
	);

	// table engine: owns the line status, so errors it finds freeze the line
	// even though the front end keeps tokenizing
	sfr_back #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.op      (pop_op),
		.pop     (pop),
		.rsp     (rsp)
	);

endmodule

// ===== tb/subfont_record_parser_tb.sv =====
// self-checking testbench for subfont_record_parser: directed rows then random record lines
// depends on sfr_pkg, sfr_ifs and the rtl of the parser; standalone, no files read
module subfont_record_parser_tb;
	import sfr_pkg::*;

	localparam int TABLE_ENTRIES = 256;
	localparam int unsigned CODE_TOP = 32'h0000_FFFF;
	localparam int QUIET_LIMIT = 4000;   // cycles with no transfer on either side
	localparam int DRAIN_CYCLES = 64;
	localparam int ITEMS_PER_PHASE = 185;

	localparam logic CMD_FEED = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;
	localparam logic [7:0] END_OF_LINE = 8'h00;
	localparam bit FIXED = 1'b1;       // row carries its own expected result
	localparam bit PREDICTED = 1'b0;   // row is checked against the predictor only

	typedef struct packed {
		logic        line_done;
		status_t     status;
		logic        code_valid;
		logic [15:0] code;
	} rsp_item_t;

	typedef struct {
		logic      cmd;
		string     text;
		logic [7:0] pos;
		bit        typed;
		rsp_item_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sfr_req_if req_ch();
	sfr_rsp_if rsp_ch();

	subfont_record_parser #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #4 clk = ~clk;

	// predictor copy of the block state
	bit          mark_q [TABLE_ENTRIES];
	logic [15:0] code_q [TABLE_ENTRIES];
	phase_t      parse_ph;
	bit          in_second;     // reading B of an A_B token
	int unsigned acc;
	base_t       num_base;
	int unsigned first_code;
	int unsigned wr_pos;
	status_t     line_st;
	bit          line_active;
	bit          negative;

	rsp_item_t   awaited_rsp[$];
	dir_row_t    dir_rows[$];
	logic [7:0]  line_chars[$];

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int fail_count = 0;
	int item_count = 0;
	int quiet_cycles = 0;
	rsp_item_t seen_rsp;
	rsp_item_t want_rsp;

	function automatic bit is_blank(input int c);
		return c == 32 || (c >= 9 && c <= 13);
	endfunction

	function automatic int radix_now();
		case (num_base)
			BASE_HEX: return 16;
			BASE_OCT: return 8;
			default:  return 10;
		endcase
	endfunction

	function automatic void set_fail(input status_t st);
		line_st = st;
		parse_ph = PH_SKIP;
	endfunction

	// accumulator saturates, and any nonzero negative number saturates at once
	function automatic void push_digit(input int d);
		int unsigned v;
		v = acc * radix_now() + d;
		if (v > ACC_SAT) v = ACC_SAT;
		if (negative && v != 0) v = ACC_SAT;
		acc = v;
	endfunction

	function automatic void begin_digits(input int ci);
		acc = 0;
		if (ci == "0") begin
			num_base = BASE_OCT;
			parse_ph = PH_ZERO;
		end else begin
			num_base = BASE_DEC;
			push_digit(ci - "0");
			parse_ph = PH_NUM;
		end
	endfunction

	// fails a reversed or overflowing range, else writes lo..hi from the write position; stops at the first marked entry
	function automatic bit fill_range(input int unsigned lo, input int unsigned hi);
		if (hi < lo) begin
			set_fail(ST_RANGE);
			return 1'b0;
		end
		if (wr_pos + (hi - lo) > TABLE_ENTRIES - 1) begin
			set_fail(ST_OVERFLOW);
			return 1'b0;
		end
		for (int unsigned cd = lo; cd <= hi; cd++) begin
			if (wr_pos >= TABLE_ENTRIES || mark_q[wr_pos]) begin
				set_fail(ST_TAKEN);
				return 1'b0;
			end
			code_q[wr_pos] = cd[15:0];
			mark_q[wr_pos] = 1'b1;
			wr_pos++;
		end
		return 1'b1;
	endfunction

	// expected result of one request; updates the predictor state
	function automatic rsp_item_t parse_and_lookup(input logic cmd_i, input logic [7:0] ch_i,
		input logic [7:0] pos_i);
		rsp_item_t r;
		int ci;
		int d;
		int unsigned v;
		r = '0;
		ci = ch_i;
		if (cmd_i == CMD_LOOKUP) begin
			if (int'(pos_i) < TABLE_ENTRIES && mark_q[pos_i]) begin
				r.code_valid = 1'b1;
				r.code = code_q[pos_i];
			end
		end else begin
			// first character of a line opens it and forgets the previous table
			if (!line_active) begin
				foreach (mark_q[i]) mark_q[i] = 1'b0;
				parse_ph = PH_BETWEEN;
				acc = 0;
				num_base = BASE_DEC;
				first_code = 0;
				wr_pos = 0;
				line_st = ST_PROGRESS;
				negative = 1'b0;
				line_active = 1'b1;
			end
			if (ci >= "0" && ci <= "9") d = ci - "0";
			else if (ci >= "a" && ci <= "f") d = ci - "a" + 10;
			else if (ci >= "A" && ci <= "F") d = ci - "A" + 10;
			else d = 16;
			if (parse_ph == PH_BETWEEN || parse_ph == PH_UNDER) begin
				// blanks separate tokens, blanks may also follow the underscore
				if (!(is_blank(ci) || (ci == 0 && parse_ph == PH_BETWEEN))) begin
					in_second = (parse_ph == PH_UNDER);
					if (ci == "+" || ci == "-") begin
						negative = (ci == "-");
						acc = 0;
						parse_ph = PH_SIGN;
					end else if (d < 10) begin
						negative = 1'b0;
						begin_digits(ci);
					end else begin
						set_fail(ST_MALFORMED);
					end
				end
			end else if (parse_ph == PH_SIGN) begin
				if (d < 10) begin_digits(ci);
				else set_fail(ST_MALFORMED);
			end else if (parse_ph == PH_X) begin
				if (d < 16) begin
					acc = 0;
					push_digit(d);
					parse_ph = PH_NUM;
				end else begin
					set_fail(ST_MALFORMED);
				end
			end else if (parse_ph == PH_ZERO && (ci == "x" || ci == "X")) begin
				num_base = BASE_HEX;
				parse_ph = PH_X;
			end else if (parse_ph != PH_SKIP) begin
				if (d < radix_now()) begin
					push_digit(d);
					parse_ph = PH_NUM;
				end else begin
					// first non-digit ends the number and decides the token
					v = acc;
					if (in_second) begin
						// range check of B comes before its terminator check
						if (v > CODE_TOP) set_fail(ST_RANGE);
						else if (!is_blank(ci) && ci != 0) set_fail(ST_MALFORMED);
						else if (fill_range(first_code, v)) parse_ph = PH_BETWEEN;
					end else if (is_blank(ci) || ci == 0) begin
						if (v > CODE_TOP) set_fail(ST_RANGE);
						else if (fill_range(v, v)) parse_ph = PH_BETWEEN;
					end else if (ci == ":") begin
						if (v > TABLE_ENTRIES - 1) set_fail(ST_RANGE);
						else begin
							wr_pos = v;
							parse_ph = PH_BETWEEN;
						end
					end else if (ci == "_") begin
						if (v > CODE_TOP) set_fail(ST_RANGE);
						else begin
							first_code = v;
							parse_ph = PH_UNDER;
						end
					end else begin
						set_fail(ST_MALFORMED);
					end
				end
			end
			if (ci == 0) begin
				if (line_st == ST_PROGRESS) line_st = ST_ACCEPTED;
				r.line_done = 1'b1;
				line_active = 1'b0;
				parse_ph = PH_BETWEEN;
			end
		end
		r.status = line_st;
		return r;
	endfunction

	function automatic void add_row(input logic cmd_i, input string txt, input logic [7:0] p,
		input bit typed, input status_t st, input logic cv = 1'b0, input logic [15:0] cd = 16'h0);
		dir_row_t r;
		r.cmd = cmd_i;
		r.text = txt;
		r.pos = p;
		r.typed = typed;
		r.want = '{line_done: (cmd_i == CMD_FEED), status: st, code_valid: cv, code: cd};
		dir_rows.push_back(r);
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_chars.push_back(s[i]);
	endfunction

	function automatic void add_blanks();
		int c;
		repeat ($urandom_range(1, 3)) begin
			c = $urandom_range(5);
			line_chars.push_back((c == 5) ? 8'd32 : 8'(9 + c));
		end
	endfunction

	// number in a random base-0 spelling, now and then signed
	function automatic string number_text(input int unsigned v);
		string s;
		case ($urandom_range(3))
			0: s = $sformatf("%0d", v);
			1: begin
				s = $sformatf("%0h", v);
				if ($urandom_range(1)) s = s.toupper();
				if ($urandom_range(1)) s = {"0x", s};
				else s = {"0X", s};
			end
			2: s = $sformatf("0%0o", v);
			default: s = $sformatf("%0d", v);
		endcase
		case ($urandom_range(19))
			0: s = {"+", s};
			1: begin
				if ($urandom_range(1)) s = "-0";
				else s = {"-", s};
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic int unsigned pick_code();
		case ($urandom_range(9))
			0: return $urandom_range(32'h0800_0000, 32'h0001_0000);
			1, 2, 3, 4: return $urandom_range(255);
			default: return $urandom_range(16'hFFFF);
		endcase
	endfunction

	// one request transfer; the expectation is taken at the accepting edge
	task automatic send_item(input logic cmd_i, input logic [7:0] ch_i, input logic [7:0] pos_i,
		input bit use_typed, input rsp_item_t typed);
		rsp_item_t exp_r;
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd_i;
		req_ch.ch <= ch_i;
		req_ch.position <= pos_i;
		do @(posedge clk); while (!req_ch.ready);
		exp_r = parse_and_lookup(cmd_i, ch_i, pos_i);
		if (use_typed) exp_r = typed;
		awaited_rsp.push_back(exp_r);
		item_count++;
	endtask

	task automatic wait_for_results();
		while (awaited_rsp.size() != 0) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// result side: random stalls, each transfer compared with the oldest expectation
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen_rsp.line_done = rsp_ch.line_done;
			seen_rsp.status = status_t'(rsp_ch.status);
			seen_rsp.code_valid = rsp_ch.code_valid;
			seen_rsp.code = rsp_ch.code;
			if (awaited_rsp.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: done=%0d st=%0d cv=%0d code=%h",
						seen_rsp.line_done, seen_rsp.status, seen_rsp.code_valid, seen_rsp.code);
			end else begin
				want_rsp = awaited_rsp.pop_front();
				if (seen_rsp.line_done !== want_rsp.line_done || seen_rsp.status !== want_rsp.status
					|| seen_rsp.code_valid !== want_rsp.code_valid
					|| seen_rsp.code !== want_rsp.code) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected done=%0d st=%0d cv=%0d code=%h, got done=%0d st=%0d cv=%0d code=%h",
							want_rsp.line_done, want_rsp.status, want_rsp.code_valid,
							want_rsp.code, seen_rsp.line_done, seen_rsp.status,
							seen_rsp.code_valid, seen_rsp.code);
				end
			end
		end
	end

	// watchdog on cycles where neither channel has a transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("subfont_record_parser verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int target;
		int n;
		int kind;
		int unsigned a;
		int unsigned b;

		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_FEED;
		req_ch.ch = 8'h00;
		req_ch.position = 8'h00;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;

		// predictor at reset
		foreach (mark_q[i]) mark_q[i] = 1'b0;
		parse_ph = PH_BETWEEN;
		in_second = 1'b0;
		acc = 0;
		num_base = BASE_DEC;
		first_code = 0;
		wr_pos = 0;
		line_st = ST_PROGRESS;
		line_active = 1'b0;
		negative = 1'b0;

		// directed rows: fixed results only where they are plain to see
		add_row(CMD_LOOKUP, "", 8'd0, FIXED, ST_PROGRESS);
		add_row(CMD_FEED, "", 8'd0, FIXED, ST_ACCEPTED);
		add_row(CMD_FEED, "65 0x41 0101", 8'd0, FIXED, ST_ACCEPTED);
		add_row(CMD_LOOKUP, "", 8'd2, FIXED, ST_ACCEPTED, 1'b1, 16'd65);
		add_row(CMD_FEED, "0:0xFFFF 255:0_0", 8'd0, FIXED, ST_ACCEPTED);
		add_row(CMD_LOOKUP, "", 8'd255, FIXED, ST_ACCEPTED, 1'b1, 16'h0000);
		add_row(CMD_LOOKUP, "", 8'd0, FIXED, ST_ACCEPTED, 1'b1, 16'hFFFF);
		add_row(CMD_LOOKUP, "", 8'd1, FIXED, ST_ACCEPTED);
		// tab, vertical tab and form feed as separators, minus zero is a plain zero
		add_row(CMD_FEED, "\011+7 -0\01310_12 \014", 8'd0, FIXED, ST_ACCEPTED);
		add_row(CMD_LOOKUP, "", 8'd1, FIXED, ST_ACCEPTED, 1'b1, 16'h0000);
		add_row(CMD_LOOKUP, "", 8'd4, FIXED, ST_ACCEPTED, 1'b1, 16'd12);
		add_row(CMD_FEED, "-5", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "256:", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "0x", 8'd0, FIXED, ST_MALFORMED);
		add_row(CMD_FEED, "+ 1", 8'd0, FIXED, ST_MALFORMED);
		add_row(CMD_FEED, "12a", 8'd0, FIXED, ST_MALFORMED);
		add_row(CMD_FEED, "99999999", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "70000_1", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "1_70000x", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "5_3", 8'd0, FIXED, ST_RANGE);
		add_row(CMD_FEED, "7_", 8'd0, FIXED, ST_MALFORMED);
		add_row(CMD_FEED, "255:1_2", 8'd0, FIXED, ST_OVERFLOW);
		// range runs into a marked entry, the first three codes stay
		add_row(CMD_FEED, "3:7 0:1_9", 8'd0, FIXED, ST_TAKEN);
		add_row(CMD_LOOKUP, "", 8'd2, FIXED, ST_TAKEN, 1'b1, 16'd3);
		add_row(CMD_LOOKUP, "", 8'd3, FIXED, ST_TAKEN, 1'b1, 16'd7);
		add_row(CMD_FEED, "1 x 99999999", 8'd0, FIXED, ST_MALFORMED);
		add_row(CMD_FEED, "0:1_ \n 3 077 0XaF:", 8'd0, PREDICTED, ST_PROGRESS);
		add_row(CMD_LOOKUP, "", 8'd3, PREDICTED, ST_PROGRESS);
		add_row(CMD_LOOKUP, "", 8'd200, PREDICTED, ST_PROGRESS);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 8;
		rx_stall_pct = 8;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].cmd == CMD_LOOKUP) begin
				send_item(CMD_LOOKUP, 8'($urandom), dir_rows[r].pos, dir_rows[r].typed,
					dir_rows[r].want);
			end else begin
				for (int i = 0; i < dir_rows[r].text.len(); i++)
					send_item(CMD_FEED, dir_rows[r].text[i], 8'($urandom), PREDICTED, '0);
				send_item(CMD_FEED, END_OF_LINE, 8'($urandom), dir_rows[r].typed,
					dir_rows[r].want);
			end
		end

		// random lines: no idling, sender gaps, receiver stalls, then both
		target = item_count;
		for (int phase_i = 0; phase_i < 4; phase_i++) begin
			case (phase_i)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
				default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
			endcase
			// hold the sender back once until the result side has emptied
			if (phase_i == 2) wait_for_results();
			target += ITEMS_PER_PHASE;
			while (item_count < target) begin
				line_chars.delete();
				if ($urandom_range(9) == 0) begin
					// pure noise line
					repeat ($urandom_range(1, 10)) line_chars.push_back(8'($urandom_range(1, 255)));
				end else begin
					n = $urandom_range(1, 6);
					if ($urandom_range(3) == 0) add_blanks();
					repeat (n) begin
						kind = $urandom_range(99);
						if (kind < 20) begin
							// set the write position, sometimes past the table
							a = ($urandom_range(15) == 0) ? $urandom_range(4095, 256)
								: $urandom_range(255);
							add_text({number_text(a), ":"});
						end else if (kind < 50) begin
							add_text(number_text(pick_code()));
						end else if (kind < 88) begin
							// short ranges mostly, a few long or reversed
							a = pick_code();
							b = ($urandom_range(29) == 0) ? a + $urandom_range(255)
								: a + $urandom_range(7);
							if ($urandom_range(14) == 0 && a > 0) b = a - 1;
							add_text({number_text(a), "_"});
							if ($urandom_range(4) == 0) add_blanks();
							add_text(number_text(b));
						end else if (kind < 94) begin
							// broken fragments
							case ($urandom_range(4))
								0: add_text("0x");
								1: add_text("+");
								2: add_text("-");
								3: add_text("_");
								default: add_text("0x_");
							endcase
						end else begin
							repeat ($urandom_range(1, 3))
								line_chars.push_back(8'($urandom_range(1, 255)));
						end
						if ($urandom_range(19) != 0) add_blanks();
					end
				end
				line_chars.push_back(END_OF_LINE);
				foreach (line_chars[i]) begin
					// lookups in the middle of an open line
					while ($urandom_range(7) == 0)
						send_item(CMD_LOOKUP, 8'($urandom),
							($urandom_range(1) ? 8'($urandom_range(15)) : 8'($urandom)),
							PREDICTED, '0);
					send_item(CMD_FEED, line_chars[i], 8'($urandom), PREDICTED, '0);
				end
			end
		end

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && awaited_rsp.size() == 0) begin
			$display("subfont_record_parser verification clean");
		end else begin
			$display("subfont_record_parser verification failed");
		end
		$finish;
	end

endmodule
